/* hdl/button_debounce_press_hold_core_macros.svh */
// Assertion macros, clocked on clk, quiet while rst is high
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_CORE_MACROS_SVH

`define BDPH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define BDPH_ASSERT_IMP(name, cond, expect_next, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

/* hdl/bdph_pkg.sv */
package bdph_pkg;

  localparam int BUTTONS = 8;

  localparam int RAW_W   = 8;
  localparam int MASK_W  = 8;
  localparam int CNT_W   = 8;
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;

  localparam int IN_DATA_W  = RAW_W + TIME_W;
  localparam int OUT_DATA_W = 3 * MASK_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0]   THRESHOLD_RESET  = CNT_W'(4);
  localparam logic [DELAY_W-1:0] HOLD_DELAY_RESET = '0;

  typedef enum logic [1:0] {
    PH_FREE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HELD     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  typedef struct packed {
    logic pressed;
    logic released;
    logic held;
  } lane_flags_t;

endpackage

/* hdl/bdph_lane.sv */
module bdph_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          raw,
  input  logic [bdph_pkg::TIME_W-1:0]   now,
  input  logic [bdph_pkg::CNT_W-1:0]    threshold,
  input  logic [bdph_pkg::DELAY_W-1:0]  hold_delay,
  output bdph_pkg::lane_flags_t         flags
);

  logic [bdph_pkg::CNT_W-1:0]  integrator, integrator_next;
  logic                        level, level_next;
  bdph_pkg::phase_t            phase, phase_next;
  logic [bdph_pkg::TIME_W-1:0] hold_start, hold_start_next;
  logic [bdph_pkg::TIME_W-1:0] elapsed;

  always_comb begin
    if (raw) begin
      integrator_next = (integrator < threshold) ? integrator + 1'b1 : threshold;
    end else if (integrator != '0) begin
      integrator_next = integrator - 1'b1;
    end else begin
      integrator_next = integrator;
    end

    // hysteresis: set at threshold, clear only at zero
    priority if (integrator_next == '0) begin
      level_next = 1'b0;
    end else if (integrator_next >= threshold) begin
      level_next = 1'b1;
    end else begin
      level_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      level      <= 1'b0;
      phase      <= bdph_pkg::PH_FREE;
      hold_start <= '0;
    end else if (en) begin
      integrator <= integrator_next;
      level      <= level_next;
      phase      <= phase_next;
      hold_start <= hold_start_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    hold_start_next = hold_start;
    unique case (phase)
      bdph_pkg::PH_FREE: begin
        if (level_next) phase_next = bdph_pkg::PH_PRESSED;
      end
      bdph_pkg::PH_PRESSED: begin
        if (level_next) begin
          phase_next      = bdph_pkg::PH_HELD;
          hold_start_next = now;
        end else begin
          phase_next = bdph_pkg::PH_RELEASED;
        end
      end
      bdph_pkg::PH_HELD: begin
        if (!level_next) phase_next = bdph_pkg::PH_RELEASED;
      end
      bdph_pkg::PH_RELEASED: begin
        phase_next = bdph_pkg::PH_FREE;
      end
      default: begin
        phase_next = bdph_pkg::PH_FREE;
      end
    endcase

    elapsed        = now - hold_start_next;
    flags.pressed  = (phase_next == bdph_pkg::PH_PRESSED);
    flags.released = (phase_next == bdph_pkg::PH_RELEASED);
    flags.held     = (phase_next == bdph_pkg::PH_HELD) &&
                     ((hold_delay == '0) ||
                      (elapsed >= bdph_pkg::TIME_W'(hold_delay)));
  end

endmodule

/* hdl/button_debounce_press_hold_core.sv */
// Eight-button debouncer with a free/pressed/held/released sequence per button.
// Each transfer on the s side is one scan tick; it produces exactly one m-side
// transfer carrying the pressed, released and held masks after that tick.
// One tick is accepted every clock cycle while the m side does not stall; each tick
// passes the input register, then one update of all lanes into the result register.
// The rate is set by the per-lane integrator, level latch and phase update, which
// are all done in that one update. Registers: index 0 is the debounce threshold
// (reset 4, a threshold of 0 keeps every button free), index 1 the hold delay
// in ms (reset 0, held shows at once). Writes to other indexes are ignored.
// Write registers only while no tick is in flight.
module button_debounce_press_hold_core (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bdph_pkg::IN_DATA_W-1:0]    s_tdata,   // button_bits[7:0], now_ms[39:8]

  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bdph_pkg::OUT_DATA_W-1:0]   m_tdata,   // pressed_mask[7:0],
                                                       // released_mask[15:8],
                                                       // held_mask[23:16]

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bdph_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdph_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [bdph_pkg::CNT_W-1:0]   threshold;
  logic [bdph_pkg::DELAY_W-1:0] hold_delay;

  logic                         in_valid;
  logic [bdph_pkg::RAW_W-1:0]   in_bits;
  logic [bdph_pkg::TIME_W-1:0]  in_now;

  logic                         out_valid;
  logic [bdph_pkg::MASK_W-1:0]  pressed_mask, released_mask, held_mask;
  logic [bdph_pkg::MASK_W-1:0]  pressed_next, released_next, held_next;

  logic                         advance;
  logic                         lane_en;
  logic [bdph_pkg::BUTTONS-1:0] lane_raw;
  bdph_pkg::lane_flags_t        lane_flags [bdph_pkg::BUTTONS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= bdph_pkg::THRESHOLD_RESET;
      hold_delay <= bdph_pkg::HOLD_DELAY_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == bdph_pkg::CFG_THRESHOLD) begin
        threshold <= cfg_data[bdph_pkg::CNT_W-1:0];
      end
      if (cfg_index == bdph_pkg::CFG_HOLD_DELAY) begin
        hold_delay <= cfg_data[bdph_pkg::DELAY_W-1:0];
      end
    end
  end

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign lane_en  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_bits <= s_tdata[bdph_pkg::RAW_W-1:0];
      in_now  <= s_tdata[bdph_pkg::IN_DATA_W-1:bdph_pkg::RAW_W];
    end
  end

  for (genvar i = 0; i < bdph_pkg::BUTTONS; i++) begin : g_lane
    if (i < bdph_pkg::RAW_W) begin : g_raw
      assign lane_raw[i] = in_bits[i];
    end else begin : g_noraw
      assign lane_raw[i] = 1'b0;
    end

    bdph_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .en         (lane_en),
      .raw        (lane_raw[i]),
      .now        (in_now),
      .threshold  (threshold),
      .hold_delay (hold_delay),
      .flags      (lane_flags[i])
    );
  end

  for (genvar b = 0; b < bdph_pkg::MASK_W; b++) begin : g_mask
    if (b < bdph_pkg::BUTTONS) begin : g_used
      assign pressed_next[b]  = lane_flags[b].pressed;
      assign released_next[b] = lane_flags[b].released;
      assign held_next[b]     = lane_flags[b].held;
    end else begin : g_unused
      assign pressed_next[b]  = 1'b0;
      assign released_next[b] = 1'b0;
      assign held_next[b]     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_en) begin
      pressed_mask  <= pressed_next;
      released_mask <= released_next;
      held_mask     <= held_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {held_mask, released_mask, pressed_mask};

endmodule

/* hdl/bdph_checker.sv */
`include "button_debounce_press_hold_core_macros.svh"

module bdph_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [bdph_pkg::OUT_DATA_W-1:0]   m_tdata
);

  logic [bdph_pkg::MASK_W-1:0] pm, rm, hm;
  logic [bdph_pkg::MASK_W-1:0] last_pm, last_rm;
  logic [bdph_pkg::MASK_W-1:0] overlap;
  logic                        m_xfer;
  logic                        m_stall;

  assign pm      = m_tdata[bdph_pkg::MASK_W-1:0];
  assign rm      = m_tdata[2*bdph_pkg::MASK_W-1:bdph_pkg::MASK_W];
  assign hm      = m_tdata[3*bdph_pkg::MASK_W-1:2*bdph_pkg::MASK_W];
  assign overlap = (pm & rm) | (pm & hm) | (rm & hm);
  assign m_xfer  = m_tvalid && m_tready;
  assign m_stall = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pm <= '0;
      last_rm <= '0;
    end else if (m_xfer) begin
      last_pm <= pm;
      last_rm <= rm;
    end
  end

  `BDPH_ASSERT_IMP(a_stall_hold, m_stall, m_tvalid && $stable(m_tdata), "result changed in stall")

  `BDPH_ASSERT(a_phase_exclusive, !m_tvalid || (overlap == '0), "button in two phases at once")

  // pressed lasts one tick, then held or released
  `BDPH_ASSERT(a_pressed_once, !m_xfer || ((pm & last_pm) == '0), "pressed twice in a row")

  // released is always followed by free
  `BDPH_ASSERT(a_released_once, !m_xfer || ((rm & last_rm) == '0), "released twice in a row")

endmodule

bind button_debounce_press_hold_core bdph_checker u_bdph_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* dv/tb_button_debounce_press_hold_core.sv */
`timescale 1ns / 100ps

module tb_button_debounce_press_hold_core;
  import bdph_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(2);

  typedef enum {OP_TICK, OP_SETTLE, OP_CFG} op_kind_t;

  typedef struct {
    op_kind_t                kind;
    logic                    quiet;
    logic [RAW_W-1:0]        bits;
    logic [TIME_W-1:0]       ms;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
  } scan_op_t;

  // same layout as m_tdata
  typedef struct packed {
    logic [MASK_W-1:0] held;
    logic [MASK_W-1:0] released;
    logic [MASK_W-1:0] pressed;
  } mask_set_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  button_debounce_press_hold_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  scan_op_t        scan_ops[$];
  mask_set_t       expected_masks[$];
  int              mismatches = 0;
  logic            quiet = 1'b0;
  logic [TIME_W-1:0] ms_stamp = '0;

  // predicted block state
  logic [CNT_W-1:0]   dbc_threshold = THRESHOLD_RESET;
  logic [DELAY_W-1:0] hold_ms = HOLD_DELAY_RESET;
  logic [CNT_W-1:0]   integ [BUTTONS];
  logic               level [BUTTONS];
  phase_t             lane_phase [BUTTONS];
  logic [TIME_W-1:0]  hold_start [BUTTONS];

  function automatic mask_set_t debounce_scan(input logic [RAW_W-1:0] raw,
                                              input logic [TIME_W-1:0] ms);
    mask_set_t r;
    logic [CNT_W-1:0] cnt;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      cnt = integ[i];
      if (raw[i]) begin
        cnt = (cnt < dbc_threshold) ? cnt + 1'b1 : dbc_threshold;
      end else if (cnt != 0) begin
        cnt = cnt - 1'b1;
      end
      integ[i] = cnt;
      if (cnt == 0) level[i] = 1'b0;
      else if (cnt >= dbc_threshold) level[i] = 1'b1;
      case (lane_phase[i])
        PH_FREE: begin
          if (level[i]) lane_phase[i] = PH_PRESSED;
        end
        PH_PRESSED: begin
          if (level[i]) begin
            lane_phase[i] = PH_HELD;
            hold_start[i] = ms;
          end else begin
            lane_phase[i] = PH_RELEASED;
          end
        end
        PH_HELD: begin
          if (!level[i]) lane_phase[i] = PH_RELEASED;
        end
        default: lane_phase[i] = PH_FREE;
      endcase
      elapsed = ms - hold_start[i];
      case (lane_phase[i])
        PH_PRESSED:  r.pressed[i] = 1'b1;
        PH_RELEASED: r.released[i] = 1'b1;
        PH_HELD:     r.held[i] = (hold_ms == 0) || (elapsed >= TIME_W'(hold_ms));
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic push_tick(input logic [RAW_W-1:0] bits, input logic [TIME_W-1:0] ms,
                           input logic q);
    scan_op_t op;
    op = '{kind: OP_TICK, quiet: q, bits: bits, ms: ms, idx: '0, data: '0};
    scan_ops.push_back(op);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                          input logic q);
    scan_op_t op;
    op = '{kind: OP_SETTLE, quiet: q, bits: '0, ms: '0, idx: '0, data: '0};
    scan_ops.push_back(op);
    op = '{kind: OP_CFG, quiet: q, bits: '0, ms: '0, idx: idx, data: data};
    scan_ops.push_back(op);
  endtask

  // stable presses and releases per button, with bounce and some junk ticks
  task automatic add_phase(input int p);
    logic [CNT_W-1:0]   thr;
    logic [DELAY_W-1:0] dly;
    logic [RAW_W-1:0]   want, raw;
    int len, flip_div;
    logic q, jumpy, noisy;
    case (p % 6)
      0: thr = CNT_W'(1);
      1: thr = CNT_W'(2);
      2: thr = CNT_W'($urandom_range(3, 8));
      3: thr = CNT_W'(4);
      4: thr = CNT_W'($urandom_range(9, 40));
      default: thr = (p == 5) ? 8'd255 : CNT_W'($urandom_range(1, 6));
    endcase
    case (p % 4)
      0: dly = '0;
      1: dly = DELAY_W'(1);
      2: dly = DELAY_W'($urandom_range(2, 40));
      default: dly = 16'hFFFF;
    endcase
    len = (thr >= 100) ? 300 : (thr >= 9) ? 150 : 65;
    q = (p % 4 == 3) || (p == 17);
    jumpy = (dly == 16'hFFFF) || (p % 5 == 0);
    noisy = p[0];
    flip_div = 3 * thr + 6;
    ms_stamp = (p % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom;
    want = RAW_W'($urandom);
    push_cfg(CFG_THRESHOLD, CFG_DATA_W'(thr), q);
    push_cfg(CFG_HOLD_DELAY, dly, q);
    for (int n = 0; n < len; n++) begin
      for (int b = 0; b < RAW_W; b++)
        if ($urandom_range(0, flip_div) == 0) want[b] = ~want[b];
      raw = want;
      if (noisy)
        for (int b = 0; b < RAW_W; b++)
          if ($urandom_range(0, 11) == 0) raw[b] = ~raw[b];
      if ($urandom_range(0, 19) == 0) raw = RAW_W'($urandom);
      if (jumpy && $urandom_range(0, 9) == 0) ms_stamp += $urandom_range(1000, 70000);
      else ms_stamp += $urandom_range(0, 3);
      push_tick(raw, ms_stamp, q);
    end
  endtask

  // driver
  int ticks_sent = 0;
  int results_seen = 0;
  int gap_left = 0;
  int settle_cnt = 0;

  always @(posedge clk) begin : drive_ticks
    scan_op_t op;
    logic tv, cv;
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      tv = s_tvalid && !s_tready;
      cv = cfg_valid && !cfg_ready;
      if (s_tvalid && s_tready) ticks_sent++;
      if (m_tvalid && m_tready) results_seen++;
      if (!tv && !cv && scan_ops.size() != 0) begin
        op = scan_ops[0];
        case (op.kind)
          OP_TICK: begin
            if (gap_left != 0) begin
              gap_left--;
            end else if (!op.quiet && $urandom_range(0, 6) == 0) begin
              gap_left = $urandom_range(1, 11) - 1;
            end else begin
              tv = 1'b1;
              s_tdata <= {op.ms, op.bits};
              void'(scan_ops.pop_front());
            end
          end
          OP_SETTLE: begin
            if (ticks_sent != results_seen) begin
              settle_cnt = 0;
            end else if (settle_cnt >= SETTLE_CYCLES) begin
              settle_cnt = 0;
              void'(scan_ops.pop_front());
            end else begin
              settle_cnt++;
            end
          end
          default: begin
            cv = 1'b1;
            cfg_index <= op.idx;
            cfg_data <= op.data;
            void'(scan_ops.pop_front());
          end
        endcase
        quiet <= op.quiet;
      end
      s_tvalid <= tv;
      cfg_valid <= cv;
    end
  end

  // monitor, predictor and result sink
  int stall_left = 0;

  always @(posedge clk) begin : watch_masks
    mask_set_t got, exp_m;
    logic nr;
    if (rst) begin
      m_tready <= 1'b0;
      dbc_threshold = THRESHOLD_RESET;
      hold_ms = HOLD_DELAY_RESET;
      for (int i = 0; i < BUTTONS; i++) begin
        integ[i] = '0;
        level[i] = 1'b0;
        lane_phase[i] = PH_FREE;
        hold_start[i] = '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        got = mask_set_t'(m_tdata);
        if (expected_masks.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, m_tdata);
          mismatches++;
        end else begin
          exp_m = expected_masks.pop_front();
          if (got.pressed !== exp_m.pressed) begin
            $display("%0t: pressed_mask expected %h got %h", $time, exp_m.pressed, got.pressed);
            mismatches++;
          end
          if (got.released !== exp_m.released) begin
            $display("%0t: released_mask expected %h got %h", $time, exp_m.released,
                     got.released);
            mismatches++;
          end
          if (got.held !== exp_m.held) begin
            $display("%0t: held_mask expected %h got %h", $time, exp_m.held, got.held);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESHOLD) dbc_threshold = cfg_data[CNT_W-1:0];
        else if (cfg_index == CFG_HOLD_DELAY) hold_ms = cfg_data[DELAY_W-1:0];
      end
      if (s_tvalid && s_tready)
        expected_masks.push_back(debounce_scan(s_tdata[RAW_W-1:0], s_tdata[RAW_W +: TIME_W]));
      if (stall_left != 0) begin
        stall_left--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_tready <= nr;
    end
  end

  initial begin
    logic [TIME_W-1:0] base;
    // reset thresholds: press all through the time wrap, then release
    for (int n = 0; n < 5; n++) push_tick(8'hFF, 32'hFFFF_FFFD + n, 1'b0);
    for (int n = 0; n < 6; n++) push_tick(8'h00, 32'd2 + n, 1'b0);
    // zero threshold keeps every button free
    push_cfg(CFG_THRESHOLD, 16'd0, 1'b0);
    push_tick(8'hFF, 32'd10, 1'b0);
    push_tick(8'hA5, 32'd11, 1'b0);
    // longest hold delay, write to an unused index
    base = 32'h1234_5678;
    push_cfg(CFG_THRESHOLD, 16'd3, 1'b0);
    push_cfg(CFG_HOLD_DELAY, 16'hFFFF, 1'b0);
    push_cfg(CFG_UNUSED, 16'hFFFF, 1'b0);
    for (int n = 0; n < 4; n++) push_tick(8'hFF, base + n, 1'b0);
    // threshold lowered under the count while pressed
    push_cfg(CFG_THRESHOLD, 16'd1, 1'b0);
    push_tick(8'h0F, base + 32'd65538, 1'b0);
    push_tick(8'h00, base + 32'd65539, 1'b0);
    push_tick(8'h00, base + 32'd65540, 1'b0);
    for (int p = 0; p < 18; p++) add_phase(p);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (scan_ops.size() != 0) @(posedge clk);
    @(posedge clk);
    while (s_tvalid || cfg_valid || expected_masks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_button_debounce_press_hold_core: done, clean");
    end else begin
      $display("tb_button_debounce_press_hold_core: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_button_debounce_press_hold_core: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/bdph_pkg.sv
hdl/bdph_lane.sv
hdl/button_debounce_press_hold_core.sv
hdl/bdph_checker.sv
dv/tb_button_debounce_press_hold_core.sv
